[rtl/core/psrf_pkg.sv]
// shared types, constants and the listed-register update function of the power-state register file
package psrf_pkg;

  localparam int unsigned KEY_W    = 27;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned GROUP_W  = 3;
  localparam int unsigned ENTRY_W  = KEY_W + DATA_W;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_DEFINE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] STS_LISTED = 2'd0;
  localparam logic [1:0] STS_MEMORY = 2'd1;
  localparam logic [1:0] STS_DROP   = 2'd2;

  localparam logic [DATA_W-1:0] TARGET_MASK = 32'h0000_000f;
  localparam logic [DATA_W-1:0] ACTUAL_MASK = 32'h0000_00f0;
  localparam logic [DATA_W-1:0] STICKY_MASK = 32'h0000_0300;
  localparam logic [DATA_W-1:0] ACTIVE_BOTH = 32'h0000_00ff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEFINE,
    ST_LSCAN,
    ST_LHIT,
    ST_SSCAN,
    ST_SHIT,
    ST_DONE
  } psrf_state_e;

  function automatic logic [DATA_W-1:0] listed_update(input logic [DATA_W-1:0] cur,
                                                      input logic [DATA_W-1:0] wr);
    logic [DATA_W-1:0] keep;
    logic [DATA_W-1:0] tgt;
    keep = cur & STICKY_MASK & ~wr;
    tgt  = (wr & TARGET_MASK) << 4;
    return (wr & ~ACTUAL_MASK & ~STICKY_MASK) | tgt | keep;
  endfunction

endpackage

[rtl/core/psrf_ram.sv]
// generic single-port-write ram with registered read
module psrf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/power_state_register_file.sv]
// power-state register file: listed registers and a small memory-like store
// one word at a time; a miss is answered only after the key search has stepped through
// the listed entries and then the spare entries, up to LISTED_ENTRIES + SPARE_SLOTS,
// one entry per cycle through the read port of each ram; a define passes through the define and done states
// the next word can be taken as soon as the result is held in the output register
// reset clears the fill counts and control state; ram contents need no clearing
module power_state_register_file
  import psrf_pkg::*;
#(
  parameter int unsigned LISTED_ENTRIES = 512,
  parameter int unsigned WINDOW_GROUPS  = 8,
  parameter int unsigned SPARE_SLOTS    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [GROUP_W-1:0]  window_group_i,
  input  logic [OFFSET_W-1:0] byte_offset_i,
  input  logic [DATA_W-1:0]   write_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DATA_W-1:0]   read_data_o,
  output logic [1:0]          status_o
);

  localparam int unsigned LAW = (LISTED_ENTRIES > 1) ? $clog2(LISTED_ENTRIES) : 1;
  localparam int unsigned SAW = (SPARE_SLOTS > 1) ? $clog2(SPARE_SLOTS) : 1;
  localparam int unsigned LCW = $clog2(LISTED_ENTRIES + 1);
  localparam int unsigned SCW = $clog2(SPARE_SLOTS + 1);

  psrf_state_e state_q, state_d;

  logic [1:0]          op_q, op_d;
  logic [GROUP_W-1:0]  grp_q, grp_d;
  logic [OFFSET_W-1:0] off_q, off_d;
  logic [DATA_W-1:0]   wdat_q, wdat_d;

  logic [LCW-1:0] lcnt_q, lcnt_d, lidx_q, lidx_d;
  logic [SCW-1:0] scnt_q, scnt_d, sidx_q, sidx_d;
  logic [LAW-1:0] lpidx_q, lpidx_d;
  logic [SAW-1:0] spidx_q, spidx_d;
  logic           pend_q, pend_d;
  logic [DATA_W-1:0] val_q, val_d;

  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [1:0]        res_sts_q, res_sts_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [1:0]        out_sts_q, out_sts_d;

  logic               lwe, swe;
  logic [LAW-1:0]     lwaddr;
  logic [SAW-1:0]     swaddr;
  logic [ENTRY_W-1:0] lwdata, swdata, lrdata, srdata;

  logic [KEY_W-1:0] word_key, full_key;
  logic             accept, lmatch, smatch, grp_ok;

  assign word_key = {grp_q, off_q[OFFSET_W-1:2], 2'b00};
  assign full_key = {grp_q, off_q};
  assign lmatch   = pend_q && (lrdata[ENTRY_W-1:DATA_W] == word_key);
  assign smatch   = pend_q && (srdata[ENTRY_W-1:DATA_W] == full_key);
  assign grp_ok   = {1'b0, window_group_i} < 4'(WINDOW_GROUPS);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  psrf_ram #(.WIDTH(ENTRY_W), .DEPTH(LISTED_ENTRIES), .AW(LAW)) u_listed_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwaddr),
    .wdata_i (lwdata),
    .raddr_i (lidx_q[LAW-1:0]),
    .rdata_o (lrdata)
  );

  psrf_ram #(.WIDTH(ENTRY_W), .DEPTH(SPARE_SLOTS), .AW(SAW)) u_spare_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (swaddr),
    .wdata_i (swdata),
    .raddr_i (sidx_q[SAW-1:0]),
    .rdata_o (srdata)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    grp_d      = grp_q;
    off_d      = off_q;
    wdat_d     = wdat_q;
    lcnt_d     = lcnt_q;
    lidx_d     = lidx_q;
    scnt_d     = scnt_q;
    sidx_d     = sidx_q;
    lpidx_d    = lpidx_q;
    spidx_d    = spidx_q;
    pend_d     = pend_q;
    val_d      = val_q;
    res_data_d = res_data_q;
    res_sts_d  = res_sts_q;
    lwe        = 1'b0;
    lwaddr     = lpidx_q;
    lwdata     = {word_key, val_q};
    swe        = 1'b0;
    swaddr     = spidx_q;
    swdata     = {full_key, wdat_q};
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    out_sts_d   = out_sts_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d       = operation_i;
          grp_d      = window_group_i;
          off_d      = byte_offset_i;
          wdat_d     = write_data_i;
          lidx_d     = '0;
          sidx_d     = '0;
          pend_d     = 1'b0;
          res_data_d = '0;
          res_sts_d  = STS_LISTED;
          if (operation_i == OP_NONE) begin
            state_d = ST_DONE;
          end else if (!grp_ok) begin
            res_sts_d = STS_MEMORY;
            state_d   = ST_DONE;
          end else if (operation_i == OP_DEFINE) begin
            state_d = ST_DEFINE;
          end else begin
            state_d = ST_LSCAN;
          end
        end
      end
      ST_DEFINE: begin
        if (lcnt_q != LCW'(LISTED_ENTRIES)) begin
          lwe    = 1'b1;
          lwaddr = lcnt_q[LAW-1:0];
          lwdata = {word_key, ACTIVE_BOTH};
          lcnt_d = lcnt_q + 1'b1;
        end else begin
          res_sts_d = STS_DROP;
        end
        state_d = ST_DONE;
      end
      ST_LSCAN: begin
        if (lmatch) begin
          val_d   = lrdata[DATA_W-1:0];
          pend_d  = 1'b0;
          state_d = ST_LHIT;
        end else if (lidx_q < lcnt_q) begin
          pend_d  = 1'b1;
          lpidx_d = lidx_q[LAW-1:0];
          lidx_d  = lidx_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          state_d = ST_SSCAN;
        end
      end
      ST_LHIT: begin
        res_sts_d = STS_LISTED;
        if (op_q == OP_READ) begin
          res_data_d = off_q[2] ? '0 : val_q;
        end else if (!off_q[2]) begin
          lwe    = 1'b1;
          lwdata = {word_key, listed_update(val_q, wdat_q)};
        end
        state_d = ST_DONE;
      end
      ST_SSCAN: begin
        res_sts_d = STS_MEMORY;
        if (smatch) begin
          val_d   = srdata[DATA_W-1:0];
          pend_d  = 1'b0;
          state_d = ST_SHIT;
        end else if (sidx_q < scnt_q) begin
          pend_d  = 1'b1;
          spidx_d = sidx_q[SAW-1:0];
          sidx_d  = sidx_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (op_q != OP_READ) begin
            if (scnt_q != SCW'(SPARE_SLOTS)) begin
              swe    = 1'b1;
              swaddr = scnt_q[SAW-1:0];
              scnt_d = scnt_q + 1'b1;
            end else begin
              res_sts_d = STS_DROP;
            end
          end
          state_d = ST_DONE;
        end
      end
      ST_SHIT: begin
        if (op_q == OP_READ) begin
          res_data_d = val_q;
        end else begin
          swe = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_data_q;
          out_sts_d   = res_sts_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lcnt_q      <= '0;
      scnt_q      <= '0;
      lidx_q      <= '0;
      sidx_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcnt_q      <= lcnt_d;
      scnt_q      <= scnt_d;
      lidx_q      <= lidx_d;
      sidx_q      <= sidx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    grp_q      <= grp_d;
    off_q      <= off_d;
    wdat_q     <= wdat_d;
    lpidx_q    <= lpidx_d;
    spidx_q    <= spidx_d;
    val_q      <= val_d;
    res_data_q <= res_data_d;
    res_sts_q  <= res_sts_d;
    out_data_q <= out_data_d;
    out_sts_q  <= out_sts_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_sts_q;

  a_lcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= LCW'(LISTED_ENTRIES))
    else $error("listed count beyond table size");

  a_scnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= SCW'(SPARE_SLOTS))
    else $error("spare count beyond store size");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LHIT || state_q == ST_SHIT) |=> (state_q == ST_DONE))
    else $error("hit did not complete");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= STS_DROP))
    else $error("undefined status code");

endmodule

[test/tb_power_state_register_file.sv]
// self-checking testbench for the power-state register file
module tb_power_state_register_file;
  import psrf_pkg::*;

  localparam int unsigned LISTED_ENTRIES = 512;
  localparam int unsigned WINDOW_GROUPS  = 8;
  localparam int unsigned SPARE_SLOTS    = 64;
  localparam int unsigned WORDS_PER_LEG  = 242;
  localparam int unsigned CYCLE_LIMIT    = 2500000;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [1:0]        sts;
  } psrf_result_t;

  class psrf_scoreboard;
    logic [KEY_W-1:0]  listed_key [LISTED_ENTRIES];
    logic [DATA_W-1:0] listed_val [LISTED_ENTRIES];
    logic [KEY_W-1:0]  spare_key  [SPARE_SLOTS];
    logic [DATA_W-1:0] spare_val  [SPARE_SLOTS];
    int unsigned       listed_count;
    int unsigned       spare_count;
    int unsigned       failures;
    psrf_result_t      expected_q [$];

    function void note_word(input logic [1:0] op, input logic [GROUP_W-1:0] grp,
                            input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wdata);
      logic [KEY_W-1:0] full_key;
      logic [KEY_W-1:0] word_key;
      psrf_result_t     res;
      int               hit;
      full_key = {grp, off};
      word_key = {grp, off[OFFSET_W-1:2], 2'b00};
      res.rd   = '0;
      res.sts  = STS_LISTED;
      hit      = -1;
      if (op != OP_NONE) begin
        if (int'(grp) >= WINDOW_GROUPS) begin
          res.sts = STS_MEMORY;
        end else if (op == OP_DEFINE) begin
          if (listed_count < LISTED_ENTRIES) begin
            listed_key[listed_count] = word_key;
            listed_val[listed_count] = ACTIVE_BOTH;
            listed_count++;
          end else begin
            res.sts = STS_DROP;
          end
        end else begin
          for (int i = 0; i < int'(listed_count); i++)
            if (hit < 0 && listed_key[i] == word_key) hit = i;
          if (hit >= 0) begin
            if (!off[2]) begin
              if (op == OP_READ) begin
                res.rd = listed_val[hit];
              end else begin
                // target copied to actual, sticky bits cleared by ones
                listed_val[hit] = {wdata[31:10], listed_val[hit][9:8] & ~wdata[9:8],
                                   wdata[3:0], wdata[3:0]};
              end
            end
          end else begin
            res.sts = STS_MEMORY;
            for (int i = 0; i < int'(spare_count); i++)
              if (hit < 0 && spare_key[i] == full_key) hit = i;
            if (op == OP_READ) begin
              if (hit >= 0) res.rd = spare_val[hit];
            end else if (hit >= 0) begin
              spare_val[hit] = wdata;
            end else if (spare_count < SPARE_SLOTS) begin
              spare_key[spare_count] = full_key;
              spare_val[spare_count] = wdata;
              spare_count++;
            end else begin
              res.sts = STS_DROP;
            end
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(input logic [DATA_W-1:0] rd, input logic [1:0] sts);
      psrf_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: read_data %h status %0d", $time, rd, sts);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (rd !== want.rd) begin
        $display("%0t: read_data expected %h actual %h", $time, want.rd, rd);
        failures++;
      end
      if (sts !== want.sts) begin
        $display("%0t: status expected %0d actual %0d", $time, want.sts, sts);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [1:0]          operation_i    = OP_NONE;
  logic [GROUP_W-1:0]  window_group_i = '0;
  logic [OFFSET_W-1:0] byte_offset_i  = '0;
  logic [DATA_W-1:0]   write_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [DATA_W-1:0]   read_data_o;
  logic [1:0]          status_o;

  psrf_scoreboard      sb;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         cycle_count;
  logic [KEY_W-1:0]    listed_pool [$];
  logic [KEY_W-1:0]    spare_pool  [$];

  power_state_register_file #(
    .LISTED_ENTRIES(LISTED_ENTRIES),
    .WINDOW_GROUPS (WINDOW_GROUPS),
    .SPARE_SLOTS   (SPARE_SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .window_group_i(window_group_i),
    .byte_offset_i (byte_offset_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_power_state_register_file failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(read_data_o, status_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(input logic [1:0] op, input logic [GROUP_W-1:0] grp,
                           input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wdata);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    window_group_i <= grp;
    byte_offset_i  <= off;
    write_data_i   <= wdata;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(op, grp, off, wdata);
  endtask

  task automatic directed_words();
    send_word(OP_READ,   3'd0, 24'h000000, 32'h0000_0000);
    send_word(OP_NONE,   3'd7, 24'hffffff, 32'hffff_ffff);
    send_word(OP_DEFINE, 3'd0, 24'h000010, 32'h0000_0000);
    send_word(OP_READ,   3'd0, 24'h000010, 32'h0000_0000);
    send_word(OP_READ,   3'd0, 24'h000013, 32'h0000_0000);
    send_word(OP_WRITE,  3'd0, 24'h000012, 32'hffff_ffff);
    send_word(OP_READ,   3'd0, 24'h000010, 32'h0000_0000);
    send_word(OP_WRITE,  3'd0, 24'h000010, 32'h0000_0000);
    send_word(OP_READ,   3'd0, 24'h000011, 32'h0000_0000);
    send_word(OP_DEFINE, 3'd7, 24'hffffff, 32'hffff_ffff);
    send_word(OP_READ,   3'd7, 24'hfffffd, 32'h0000_0000);
    send_word(OP_WRITE,  3'd7, 24'hfffffc, 32'hffff_ffff);
    send_word(OP_READ,   3'd7, 24'hffffff, 32'h0000_0000);
    send_word(OP_DEFINE, 3'd0, 24'h000010, 32'h0000_0000);
    send_word(OP_WRITE,  3'd0, 24'h000010, 32'h1234_5a5a);
    send_word(OP_READ,   3'd0, 24'h000010, 32'h0000_0000);
    send_word(OP_WRITE,  3'd3, 24'h000001, 32'hdead_beef);
    send_word(OP_READ,   3'd3, 24'h000001, 32'h0000_0000);
    send_word(OP_READ,   3'd3, 24'h000000, 32'h0000_0000);
    send_word(OP_WRITE,  3'd3, 24'h000001, 32'h0000_0000);
    send_word(OP_READ,   3'd3, 24'h000001, 32'h0000_0000);
    send_word(OP_READ,   3'd7, 24'hfffff8, 32'h0000_0000);
    send_word(OP_WRITE,  3'd0, 24'h000000, 32'hffff_ffff);
    send_word(OP_READ,   3'd0, 24'h000000, 32'h0000_0000);
  endtask

  task automatic random_word();
    logic [1:0]       op;
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    int unsigned      src;
    pick = $urandom_range(99);
    src  = $urandom_range(99);
    k    = KEY_W'($urandom());
    // fill the listed table first, then mostly accesses
    if (sb.listed_count < LISTED_ENTRIES) begin
      op = (pick < 76) ? OP_DEFINE : (pick < 90) ? OP_WRITE :
           (pick < 98) ? OP_READ : OP_NONE;
    end else begin
      op = (pick < 6) ? OP_DEFINE : (pick < 58) ? OP_WRITE :
           (pick < 96) ? OP_READ : OP_NONE;
    end
    if (op == OP_DEFINE) begin
      if (src < 10 && listed_pool.size() != 0)
        k = listed_pool[$urandom_range(listed_pool.size() - 1)];
      listed_pool.push_back({k[KEY_W-1:2], 2'b00});
    end else if (src < 30 && listed_pool.size() != 0) begin
      k = listed_pool[$urandom_range(listed_pool.size() - 1)] | KEY_W'($urandom_range(3));
    end else if (src < 45 && spare_pool.size() != 0) begin
      k = spare_pool[$urandom_range(spare_pool.size() - 1)];
    end else if (op == OP_WRITE) begin
      spare_pool.push_back(k);
    end
    send_word(op, k[KEY_W-1:OFFSET_W], k[OFFSET_W-1:0], $urandom());
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 17;
    recv_stall_pct = 76;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    for (int leg = 0; leg < 3; leg++) begin
      case (leg)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (WORDS_PER_LEG) random_word();
    end
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LISTED_ENTRIES + SPARE_SLOTS + 8) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("tb_power_state_register_file passed");
    end else begin
      $display("tb_power_state_register_file failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/psrf_pkg.sv
rtl/core/psrf_ram.sv
rtl/core/power_state_register_file.sv
test/tb_power_state_register_file.sv
